// File: design/nfsa_pkg.sv
// shared constants, types and helper functions for the next-fit slot allocator
`timescale 1ns / 1ps
`default_nettype none

package nfsa_pkg;

    // table geometry
    localparam int SLOTS      = 128;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int GROUP_SZ   = 8;
    localparam int GROUP_W    = $clog2(GROUP_SZ);
    localparam int GROUPS     = SLOTS / GROUP_SZ;
    localparam int GRP_IDX_W  = $clog2(GROUPS);

    // field widths
    localparam int OWNER_BITS = 32;
    localparam int MODE_W     = 2;
    localparam int IDX_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 16;

    // request kinds
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic scan;
        logic pick;
        logic read;
        logic commit_alloc;
        logic commit_check;
    } nfsa_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic req_alloc;
        logic out_free;
    } nfsa_stat_t;

    // lowest set bit of a group-flag vector
    function automatic logic [GRP_IDX_W-1:0] first_set_grp(input logic [GROUPS-1:0] v);
        logic [GRP_IDX_W-1:0] r;
        r = '0;
        for (int i = GROUPS - 1; i >= 0; i--)
        begin
            if (v[i])
                r = GRP_IDX_W'(i);
        end
        return r;
    endfunction

    // lowest set bit within one group
    function automatic logic [GROUP_W-1:0] first_set_bit(input logic [GROUP_SZ-1:0] v);
        logic [GROUP_W-1:0] r;
        r = '0;
        for (int i = GROUP_SZ - 1; i >= 0; i--)
        begin
            if (v[i])
                r = GROUP_W'(i);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/nfsa_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module nfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/nfsa_datapath.sv
// slot table, next-fit search, owner check and output word register
`timescale 1ns / 1ps
`default_nettype none

module nfsa_datapath
    import nfsa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire nfsa_cmd_t           cmd,
    output nfsa_stat_t               stat,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [MODE_W-1:0]   s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata
);

    logic [MODE_W-1:0]      mode_reg;
    logic [OWNER_BITS-1:0]  tag_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [SLOTS-1:0]       in_use_reg;
    logic [SLOTS-1:0]       in_use_next;
    logic [SLOT_W-1:0]      rover_pos_reg;
    logic [SLOT_W-1:0]      rover_pos_next;
    logic [GROUPS-1:0]      ghi_reg;
    logic [GROUPS-1:0]      gall_reg;
    logic                   use_hi_reg;
    logic                   any_reg;
    logic [GRP_IDX_W-1:0]   grp_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [IDX_W-1:0]       res_idx_reg;
    logic [STATUS_W-1:0]    res_st_reg;

    logic [SLOTS-1:0]       free_bits;
    logic [SLOTS-1:0]       hi_mask;
    logic [SLOTS-1:0]       hi_free;
    logic [GROUP_SZ-1:0]    sel_bits;
    logic [SLOT_W-1:0]      alloc_pos;
    logic [IDX_W-1:0]       idx_m1_full;
    logic [SLOT_W-1:0]      idx_m1;
    logic                   idx_ok;
    logic                   check_ok;
    logic [OWNER_BITS-1:0]  ram_rdata;
    logic                   out_free;
    logic                   alloc_commit;

    assign stat.req_alloc = (s_tuser == MODE_ALLOC);
    assign out_free       = !out_valid_reg || m_tready;
    assign stat.out_free  = out_free;

    // capture the request word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= s_tuser;
            tag_reg  <= s_tdata[OWNER_BITS-1:0];
            idx_reg  <= s_tdata[OWNER_BITS +: IDX_W];
        end
    end

    // free slots at or above the rover, per group
    assign free_bits = ~in_use_reg;
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
            hi_mask[i] = (SLOT_W'(i) >= rover_pos_reg);
    end
    assign hi_free = free_bits & hi_mask;

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                ghi_reg[g]  <= |hi_free[g*GROUP_SZ +: GROUP_SZ];
                gall_reg[g] <= |free_bits[g*GROUP_SZ +: GROUP_SZ];
            end
        end
        if (cmd.pick)
        begin
            use_hi_reg <= |ghi_reg;
            any_reg    <= |gall_reg;
            grp_reg    <= (|ghi_reg) ? first_set_grp(ghi_reg) : first_set_grp(gall_reg);
        end
    end

    // slot within the chosen group
    assign sel_bits  = use_hi_reg ? hi_free[grp_reg*GROUP_SZ +: GROUP_SZ]
                                  : free_bits[grp_reg*GROUP_SZ +: GROUP_SZ];
    assign alloc_pos = {grp_reg, first_set_bit(sel_bits)};
    assign alloc_commit = cmd.commit_alloc && any_reg;

    // owner check for free and lookup
    assign idx_m1_full = idx_reg - IDX_W'(1);
    assign idx_m1      = idx_m1_full[SLOT_W-1:0];
    assign idx_ok      = (idx_reg != '0) && (idx_reg <= IDX_W'(SLOTS));
    assign check_ok    = ((mode_reg == MODE_FREE) || (mode_reg == MODE_LOOKUP))
                         && idx_ok && in_use_reg[idx_m1] && (ram_rdata == tag_reg);

    nfsa_ram #(
        .WIDTH (OWNER_BITS),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (alloc_commit),
        .waddr (alloc_pos),
        .wdata (tag_reg),
        .re    (cmd.read),
        .raddr (idx_m1),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        in_use_next    = in_use_reg;
        rover_pos_next = rover_pos_reg;
        if (alloc_commit)
        begin
            in_use_next[alloc_pos] = 1'b1;
            rover_pos_next         = alloc_pos;
        end
        if (cmd.commit_check && check_ok && (mode_reg == MODE_FREE))
            in_use_next[idx_m1] = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (cmd.commit_alloc || cmd.commit_check)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            rover_pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_use_reg    <= in_use_next;
            rover_pos_reg <= rover_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.commit_alloc)
        begin
            res_idx_reg <= any_reg ? IDX_W'(alloc_pos) + IDX_W'(1) : '0;
            res_st_reg  <= any_reg ? ST_OK : ST_FULL;
        end
        else if (cmd.commit_check)
        begin
            res_idx_reg <= check_ok ? idx_reg : '0;
            res_st_reg  <= check_ok ? ST_OK : ST_MISS;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - IDX_W - STATUS_W){1'b0}}, res_st_reg, res_idx_reg};

    // a result is only loaded when the output register is free
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit_alloc || cmd.commit_check) |-> out_free)
        else $error("result loaded over a pending word");

    // after an allocation the rover points at an in-use slot
    a_rover_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_commit |=> in_use_reg[rover_pos_reg])
        else $error("rover slot not marked in use after allocate");

    // an ok result always names a slot, any other result names none
    a_ok_has_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((res_st_reg == ST_OK) == (res_idx_reg != '0)))
        else $error("result index does not match status");

endmodule

`default_nettype wire

// File: design/nfsa_ctrl.sv
// request sequencer for the slot allocator
`timescale 1ns / 1ps
`default_nettype none

module nfsa_ctrl
    import nfsa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire nfsa_stat_t stat,
    output nfsa_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                    state_next = stat.req_alloc ? S_SCAN : S_READ;
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_ALLOC;
            end
            S_ALLOC:
            begin
                if (stat.out_free)
                begin
                    cmd.commit_alloc = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.out_free)
                begin
                    cmd.commit_check = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // the owner check is entered only straight after an owner read
    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) && !$past(state_reg == S_CHECK) |-> $past(cmd.read))
        else $error("owner check without a preceding read");

endmodule

`default_nettype wire

// File: design/next_fit_slot_allocator.sv
// top level of the next-fit slot allocator
//
//  channel | direction | signals                           | word layout (low bit up)
//  --------+-----------+-----------------------------------+-----------------------------------
//  s       | in        | s_tvalid s_tready s_tdata s_tuser | tdata: owner_tag[31:0]
//          |           |                                   |        slot_index[39:32]
//          |           |                                   | tuser: mode[1:0]
//  m       | out       | m_tvalid m_tready m_tdata         | result_index[7:0] status[9:8]
//          |           |                                   | zero pad[15:10]
//
// allocate steps: capture, group flags, group pick, then slot pick with
//   table update (two-level search over 16 groups of 8)
// free and lookup steps: capture, owner ram read, compare
// one request is in flight at a time; s_tready is high only while idle, so the
//   next word is taken in the cycle the result word first shows on m_tvalid
// a held result stalls the next commit until m_tready frees the output register
// reset clears all in-use bits and sets the rover to slot 1; the owner ram is not cleared
`timescale 1ns / 1ps
`default_nettype none

module next_fit_slot_allocator
    import nfsa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // owner_tag, slot_index
    input  wire logic [MODE_W-1:0]   s_tuser,   // mode
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata    // result_index, status
);

    nfsa_cmd_t  cmd;
    nfsa_stat_t stat;

    // sequencer
    nfsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slot table, search and output word
    nfsa_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
